>>> hw/rtl/skst_pkg.sv
// ----------------------------------------------------------------------------
// skst_pkg: shared constants for the scan-code key state tracker
// Key count, byte codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package skst_pkg;

  // Key map geometry
  localparam int KEY_CNT   = 128;
  localparam int KEY_IDX_W = 7;
  localparam int CNT_W     = 8;

  // Received byte layout and special bytes
  localparam int          BREAK_BIT      = 7;
  localparam logic [7:0]  BYTE_CLEAR_ALL = 8'h7F;
  localparam logic [7:0]  BYTE_CMD_A     = 8'hFA;
  localparam logic [7:0]  BYTE_CMD_B     = 8'hFB;
  localparam logic [7:0]  BYTE_CMD_C     = 8'hFC;

  // Request kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Configuration register indexes
  localparam int         CFG_ADDR_W      = 2;
  localparam int         CFG_DATA_W      = 8;
  localparam logic [1:0] REG_RELEASE_DLY = 2'd0;
  localparam logic [1:0] REG_TAP_DLY     = 2'd1;
  localparam logic [1:0] REG_LOCK_FIRST  = 2'd2;
  localparam logic [1:0] REG_LOCK_SECOND = 2'd3;

  // Register reset values
  localparam logic [CNT_W-1:0]     RELEASE_DLY_RST = 8'd4;
  localparam logic [CNT_W-1:0]     TAP_DLY_RST     = 8'd8;
  localparam logic [KEY_IDX_W-1:0] LOCK_FIRST_RST  = 7'd113;
  localparam logic [KEY_IDX_W-1:0] LOCK_SECOND_RST = 7'd114;

  // A zero delay behaves as one tick
  function automatic logic [CNT_W-1:0] nz_delay(input logic [CNT_W-1:0] d);
    nz_delay = (d == '0) ? CNT_W'(1) : d;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scancode_key_state_tracker.sv
// A byte request passes through the execute and done states into the output
// register; a tick request walks all 128 key counters through one
// read/update/write-back unit, one key per cycle, before the done state.
// Throughput: one request at a time; the next is accepted once the result is
// in the output register, which holds it until taken.
// Reset (synchronous, rst_n low): keys released, all counters disarmed at once.
// ----------------------------------------------------------------------------
// scancode_key_state_tracker: pressed-key map with release and tap timers
// Tracks make/break scan codes and ticks into a 128-bit key map.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_key_state_tracker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_mode,
  input  wire logic [7:0]                      in_code_byte,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_changed,
  output logic      [63:0]                     out_keys_low,
  output logic      [63:0]                     out_keys_high,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [skst_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [skst_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int KW = skst_pkg::KEY_IDX_W;
  localparam int CW = skst_pkg::CNT_W;
  localparam int KN = skst_pkg::KEY_CNT;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic          mode_r, mode_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [CW-1:0] rel_dly_r, rel_dly_nxt;
  logic [CW-1:0] tap_dly_r, tap_dly_nxt;
  logic [KW-1:0] lock_a_r, lock_a_nxt;
  logic [KW-1:0] lock_b_r, lock_b_nxt;
  logic [KN-1:0] pressed_r, pressed_nxt;
  logic [KN-1:0] rel_vld_r, rel_vld_nxt;
  logic [KN-1:0] tap_vld_r, tap_vld_nxt;
  logic          chg_r, chg_nxt;
  logic [KW:0]   rd_idx_r, rd_idx_nxt;
  logic          s2_vld_r, s2_vld_nxt;
  logic [KW-1:0] s2_idx_r, s2_idx_nxt;
  logic          s2_rv_r, s2_rv_nxt;
  logic          s2_tv_r, s2_tv_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_chg_r, out_chg_nxt;
  logic [KN-1:0] out_keys_r, out_keys_nxt;

  // counter RAM ports
  logic          rel_we, tap_we, ram_re;
  logic [KW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] rel_wdata, tap_wdata;
  logic [CW-1:0] rel_rdata, tap_rdata;

  logic [CW-1:0] rel_cur, tap_cur;
  logic [KW-1:0] code;
  logic          is_lock;

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_changed   = out_chg_r;
  assign out_keys_low  = out_keys_r[63:0];
  assign out_keys_high = out_keys_r[KN-1:64];

  assign code    = byte_r[KW-1:0];
  assign is_lock = (code == lock_a_r) || (code == lock_b_r);

  // counters of an entry never written since reset or clear-all read as zero
  assign rel_cur = s2_rv_r ? rel_rdata : '0;
  assign tap_cur = s2_tv_r ? tap_rdata : '0;

  // release and tap countdown stores
  skst_ram #(.WIDTH(CW), .DEPTH(KN)) u_rel_ram (
    .clk   (clk),
    .we    (rel_we),
    .waddr (ram_waddr),
    .wdata (rel_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rel_rdata)
  );

  skst_ram #(.WIDTH(CW), .DEPTH(KN)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (ram_waddr),
    .wdata (tap_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (tap_rdata)
  );

  // Sequencer and key map update
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    byte_nxt      = byte_r;
    rel_dly_nxt   = rel_dly_r;
    tap_dly_nxt   = tap_dly_r;
    lock_a_nxt    = lock_a_r;
    lock_b_nxt    = lock_b_r;
    pressed_nxt   = pressed_r;
    rel_vld_nxt   = rel_vld_r;
    tap_vld_nxt   = tap_vld_r;
    chg_nxt       = chg_r;
    rd_idx_nxt    = rd_idx_r;
    s2_vld_nxt    = 1'b0;
    s2_idx_nxt    = s2_idx_r;
    s2_rv_nxt     = s2_rv_r;
    s2_tv_nxt     = s2_tv_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_chg_nxt   = out_chg_r;
    out_keys_nxt  = out_keys_r;
    rel_we        = 1'b0;
    tap_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = code;
    ram_raddr     = rd_idx_r[KW-1:0];
    rel_wdata     = skst_pkg::nz_delay(rel_dly_r);
    tap_wdata     = skst_pkg::nz_delay(tap_dly_r);

    // configuration writes
    if (cfg_we) begin
      case (cfg_addr)
        skst_pkg::REG_RELEASE_DLY: rel_dly_nxt = cfg_data;
        skst_pkg::REG_TAP_DLY:     tap_dly_nxt = cfg_data;
        skst_pkg::REG_LOCK_FIRST:  lock_a_nxt  = cfg_data[KW-1:0];
        skst_pkg::REG_LOCK_SECOND: lock_b_nxt  = cfg_data[KW-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          byte_nxt  = in_code_byte;
          chg_nxt   = 1'b0;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (mode_r == skst_pkg::MODE_TICK) begin
          rd_idx_nxt = '0;
          state_nxt  = ST_WALK;
        end else begin
          state_nxt = ST_DONE;
          if (byte_r == skst_pkg::BYTE_CMD_A || byte_r == skst_pkg::BYTE_CMD_B ||
              byte_r == skst_pkg::BYTE_CMD_C) begin
            chg_nxt = 1'b0;
          end else if (byte_r == skst_pkg::BYTE_CLEAR_ALL) begin
            pressed_nxt = '0;
            rel_vld_nxt = '0;
            tap_vld_nxt = '0;
            chg_nxt     = 1'b1;
          end else if (is_lock) begin
            // lock key: make and break both press and arm the tap timer
            chg_nxt           = ~pressed_r[code];
            pressed_nxt[code] = 1'b1;
            tap_we            = 1'b1;
            tap_vld_nxt[code] = 1'b1;
          end else if (byte_r[skst_pkg::BREAK_BIT]) begin
            rel_we            = 1'b1;
            rel_vld_nxt[code] = 1'b1;
          end else begin
            // make: press and cancel any pending release
            chg_nxt           = ~pressed_r[code];
            pressed_nxt[code] = 1'b1;
            rel_vld_nxt[code] = 1'b0;
          end
        end
      end

      ST_WALK: begin
        // read stage: one key per cycle
        if (!rd_idx_r[KW]) begin
          ram_re     = 1'b1;
          s2_vld_nxt = 1'b1;
          s2_idx_nxt = rd_idx_r[KW-1:0];
          s2_rv_nxt  = rel_vld_r[rd_idx_r[KW-1:0]];
          s2_tv_nxt  = tap_vld_r[rd_idx_r[KW-1:0]];
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        // decrement and write-back stage
        if (s2_vld_r) begin
          ram_waddr = s2_idx_r;
          rel_wdata = rel_cur - 1'b1;
          tap_wdata = tap_cur - 1'b1;
          rel_we    = (rel_cur != '0);
          tap_we    = (tap_cur != '0);
          if (rel_cur == CW'(1) || tap_cur == CW'(1)) begin
            chg_nxt               = chg_r | pressed_r[s2_idx_r];
            pressed_nxt[s2_idx_r] = 1'b0;
          end
        end
        if (rd_idx_r[KW] && !s2_vld_r) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_chg_nxt   = chg_r;
          out_keys_nxt  = pressed_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rel_dly_r   <= skst_pkg::RELEASE_DLY_RST;
      tap_dly_r   <= skst_pkg::TAP_DLY_RST;
      lock_a_r    <= skst_pkg::LOCK_FIRST_RST;
      lock_b_r    <= skst_pkg::LOCK_SECOND_RST;
      pressed_r   <= '0;
      rel_vld_r   <= '0;
      tap_vld_r   <= '0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      chg_r       <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      rel_dly_r   <= rel_dly_nxt;
      tap_dly_r   <= tap_dly_nxt;
      lock_a_r    <= lock_a_nxt;
      lock_b_r    <= lock_b_nxt;
      pressed_r   <= pressed_nxt;
      rel_vld_r   <= rel_vld_nxt;
      tap_vld_r   <= tap_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      out_valid_r <= out_valid_nxt;
      chg_r       <= chg_nxt;
      rd_idx_r    <= rd_idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    byte_r     <= byte_nxt;
    s2_idx_r   <= s2_idx_nxt;
    s2_rv_r    <= s2_rv_nxt;
    s2_tv_r    <= s2_tv_nxt;
    out_chg_r  <= out_chg_nxt;
    out_keys_r <= out_keys_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/skst_ram.sv
// ----------------------------------------------------------------------------
// skst_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module skst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
